### sv/gsig_pkg.sv
// Shared types and constants for the grid strip index generator.
package gsig_pkg;

  localparam int unsigned ChunkW   = 8;
  localparam int unsigned AreaW    = 16;
  localparam int unsigned VertexW  = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_SIDE_LEN     = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_SKIRT_ENABLE = 1'd1;

  localparam logic [ChunkW-1:0] CHUNK_RESET = 8'd33;
  localparam logic [ChunkW-1:0] CHUNK_MIN   = 8'd2;

  typedef enum logic [2:0] {
    PH_GRID   = 3'd0,
    PH_DEGEN  = 3'd1,
    PH_JOIN   = 3'd2,
    PH_BOTTOM = 3'd3,
    PH_RIGHT  = 3'd4,
    PH_TOP    = 3'd5,
    PH_LEFT   = 3'd6,
    PH_CLOSE  = 3'd7
  } phase_e;

  typedef struct packed {
    logic [ChunkW-1:0] n;      // clamped grid side
    logic [AreaW-1:0]  nn;     // n * n
    logic              skirt;
  } cfg_t;

  typedef struct packed {
    logic [VertexW-1:0] vertex_index;
    logic               last;
  } result_t;

endpackage

### sv/grid_strip_index_generator.sv
// Top level: configuration registers, input word register, index core and output word register.
//
//  channel | dir | handshake             | content
//  s_axis  | in  | tvalid/tready         | tdata[0] restart
//  m_axis  | out | tvalid/tready, tlast  | tdata[15:0] vertex_index, tlast last
//  cfg     | in  | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One index word per cycle sustained while m_axis_tready stays high; each word passes the input then output register.
// The walk state and the index adders sit between the input and output
// registers, so each word's index is formed combinationally between them.
// Reset clears the walk to its first entry, chunk size 33, skirt enabled.
// A stalled output holds its word; one further input word waits in the
// input register, after which s_axis_tready drops.
module grid_strip_index_generator #(
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [0] restart
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // [15:0] vertex_index
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [gsig_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gsig_pkg::CfgDataW-1:0] cfg_data_i
);
  import gsig_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    in_valid_q, in_restart_q;
  logic    out_valid_q, out_last_q;
  logic [VertexW-1:0] out_index_q;
  logic    advance;

  gsig_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  gsig_core #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .restart_i (in_restart_q),
    .cfg_i     (cfg),
    .result_o  (res)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance)            out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_restart_q <= s_axis_tdata[0];
    if (advance) begin
      out_index_q <= res.vertex_index;
      out_last_q  <= res.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_index_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### sv/gsig_cfg.sv
// Configuration registers, side clamp and registered grid area.
module gsig_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gsig_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gsig_pkg::CfgDataW-1:0] cfg_data_i,
  output gsig_pkg::cfg_t                cfg_o
);
  import gsig_pkg::*;

  logic [ChunkW-1:0] chunk_q;
  logic              skirt_q;
  logic [ChunkW-1:0] n_w, n_wr;
  logic [AreaW-1:0]  nn_d, nn_q;

  // area is formed from the written side, so it lands with the side itself
  assign n_wr = (cfg_data_i[ChunkW-1:0] < CHUNK_MIN) ? CHUNK_MIN : cfg_data_i[ChunkW-1:0];
  assign nn_d = AreaW'(n_wr) * AreaW'(n_wr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= CHUNK_RESET;
      skirt_q <= 1'b1;
      nn_q    <= AreaW'(CHUNK_RESET) * AreaW'(CHUNK_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIDE_LEN: begin
          chunk_q <= cfg_data_i[ChunkW-1:0];
          nn_q    <= nn_d;
        end
        CFG_SKIRT_ENABLE: skirt_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign n_w = (chunk_q < CHUNK_MIN) ? CHUNK_MIN : chunk_q;

  assign cfg_o.n     = n_w;
  assign cfg_o.nn    = nn_q;
  assign cfg_o.skirt = skirt_q;

endmodule

### sv/gsig_core.sv
// Walk state and index arithmetic for the grid strips and skirt border.
module gsig_core #(
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              restart_i,
  input  gsig_pkg::cfg_t    cfg_i,
  output gsig_pkg::result_t result_o
);
  import gsig_pkg::*;

  localparam int unsigned IW = INDEX_WIDTH;

  phase_e             phase_q, phase_d, phase_e_w;
  logic [ChunkW-1:0]  row_q, row_d, row_e;
  logic [ChunkW-1:0]  col_q, col_d, col_e;
  logic               half_q, half_d, half_e;
  logic [VertexW-1:0] prev_q, prev_d, prev_e;

  logic [AreaW-1:0]   jn;
  logic [IW-1:0]      n_w, nn_w, jn_w, j_w, k_w, idx;
  logic [ChunkW:0]    k_inc, j_inc;
  logic [ChunkW+1:0]  j_plus2, j_plus3, n_x;
  logic               last;

  // restart applies before this word's index is formed
  always_comb begin
    if (restart_i) begin
      phase_e_w = PH_GRID;
      row_e     = '0;
      col_e     = '0;
      half_e    = 1'b0;
      prev_e    = '0;
    end else begin
      phase_e_w = phase_q;
      row_e     = row_q;
      col_e     = col_q;
      half_e    = half_q;
      prev_e    = prev_q;
    end
  end

  assign jn   = AreaW'(row_e) * AreaW'(cfg_i.n);
  assign n_w  = IW'(cfg_i.n);
  assign nn_w = IW'(cfg_i.nn);
  assign jn_w = IW'(jn);
  assign j_w  = IW'(row_e);
  assign k_w  = IW'(col_e);

  always_comb begin
    case (phase_e_w)
      PH_GRID:   idx = half_e ? (jn_w + n_w + k_w) : (jn_w + k_w);
      PH_DEGEN:  idx = half_e ? (jn_w + n_w) : (jn_w + n_w + n_w - IW'(1));
      PH_JOIN:   idx = half_e ? nn_w : IW'(prev_e);
      PH_BOTTOM: idx = half_e ? k_w : (nn_w + k_w);
      PH_RIGHT:  idx = half_e ? (n_w + n_w - IW'(1) + jn_w)
                              : (nn_w + n_w + IW'(1) + j_w + j_w);
      PH_TOP:    idx = half_e ? (nn_w - IW'(1) - k_w)
                              : (nn_w + (n_w << 2) - IW'(5) - k_w);
      PH_LEFT:   idx = half_e ? (nn_w - n_w - n_w - jn_w)
                              : (nn_w + n_w + n_w + n_w - IW'(6) - j_w - j_w);
      PH_CLOSE:  idx = half_e ? '0 : nn_w;
      default:   idx = '0;
    endcase
  end

  assign k_inc   = {1'b0, col_e} + (ChunkW+1)'(1);
  assign j_inc   = {1'b0, row_e} + (ChunkW+1)'(1);
  assign j_plus2 = {2'b00, row_e} + (ChunkW+2)'(2);
  assign j_plus3 = {2'b00, row_e} + (ChunkW+2)'(3);
  assign n_x     = {2'b00, cfg_i.n};

  always_comb begin
    phase_d = phase_e_w;
    row_d   = row_e;
    col_d   = col_e;
    half_d  = ~half_e;
    prev_d  = idx[VertexW-1:0];
    last    = 1'b0;
    if (half_e) begin
      case (phase_e_w)
        PH_GRID: begin
          col_d = k_inc[ChunkW-1:0];
          if ({1'b0, k_inc} >= n_x) begin
            col_d = '0;
            if (j_plus2 >= n_x) begin
              if (cfg_i.skirt) phase_d = PH_JOIN;
              else             last    = 1'b1;
            end else begin
              phase_d = PH_DEGEN;
            end
          end
        end
        PH_DEGEN: begin
          row_d   = j_inc[ChunkW-1:0];
          col_d   = '0;
          phase_d = PH_GRID;
        end
        PH_JOIN: begin
          col_d   = '0;
          phase_d = PH_BOTTOM;
        end
        PH_BOTTOM, PH_TOP: begin
          col_d = k_inc[ChunkW-1:0];
          if ({1'b0, k_inc} >= n_x) begin
            row_d = '0;
            col_d = '0;
            // side walks are empty when the grid side is two vertices
            if (phase_e_w == PH_BOTTOM) phase_d = (cfg_i.n > CHUNK_MIN) ? PH_RIGHT : PH_TOP;
            else                        phase_d = (cfg_i.n > CHUNK_MIN) ? PH_LEFT : PH_CLOSE;
          end
        end
        PH_RIGHT: begin
          row_d = j_inc[ChunkW-1:0];
          if (j_plus3 >= n_x) begin
            row_d   = '0;
            col_d   = '0;
            phase_d = PH_TOP;
          end
        end
        PH_LEFT: begin
          row_d = j_inc[ChunkW-1:0];
          if (j_plus3 >= n_x) begin
            row_d   = '0;
            phase_d = PH_CLOSE;
          end
        end
        PH_CLOSE: last = 1'b1;
        default: ;
      endcase
    end
    if (last) begin
      phase_d = PH_GRID;
      row_d   = '0;
      col_d   = '0;
      half_d  = 1'b0;
      prev_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_GRID;
      row_q   <= '0;
      col_q   <= '0;
      half_q  <= 1'b0;
      prev_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      row_q   <= row_d;
      col_q   <= col_d;
      half_q  <= half_d;
      prev_q  <= prev_d;
    end
  end

  assign result_o.vertex_index = idx[VertexW-1:0];
  assign result_o.last         = last;

endmodule

### sv/gsig_checker.sv
// Port-level checks for the grid strip index generator, bound to the top level.
module gsig_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output word changed while stalled");

  // a fresh output word needs an input word taken earlier through the input register
  a_out_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("output word without input word");

  // input side only stalls behind a full output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  // two accepted last words never come back to back
  a_last_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast)
      |=> !(m_axis_tvalid && m_axis_tready && m_axis_tlast))
    else $error("two last words in a row");

endmodule

bind grid_strip_index_generator gsig_checker u_gsig_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
